[src/upk_pkg.sv]
// ---------------------------------------------------------------------------
// upk_pkg: shared types and helpers of the packed I/Q sample unpacker
// Sample format codes, the pair entry that travels from the front end to
// the back end, and the per-format width and sign conversion.
// ---------------------------------------------------------------------------
package upk_pkg;

	typedef enum logic [2:0] {
		FMT_S8   = 3'd0,
		FMT_U8   = 3'd1,
		FMT_S16  = 3'd2,
		FMT_U16  = 3'd3,
		FMT_P10  = 3'd4,
		FMT_P12  = 3'd5,
		FMT_P14  = 3'd6,
		FMT_NONE = 3'd7
	} fmt_t;

	localparam int unsigned StoreW = 40;
	localparam int unsigned CountW = 6;
	localparam int unsigned SampW  = 16;
	localparam int unsigned QDepth = 2;

	// Raw I and Q bits of one pair, still in their native coding.
	typedef struct packed {
		logic [SampW-1:0] i_raw;
		logic [SampW-1:0] q_raw;
		fmt_t             fmt;
	} pair_t;

	// Native sample width in bits; zero for the unused code.
	function automatic logic [4:0] fmt_width(input fmt_t fmt);
		logic [4:0] w;
		begin
			unique case (fmt)
				FMT_S8, FMT_U8:   w = 5'd8;
				FMT_S16, FMT_U16: w = 5'd16;
				FMT_P10:          w = 5'd10;
				FMT_P12:          w = 5'd12;
				FMT_P14:          w = 5'd14;
				FMT_NONE:         w = 5'd0;
			endcase
			return w;
		end
	endfunction

	// Offset-binary samples become two's complement by inverting the top bit.
	function automatic logic signed [SampW-1:0] to_s16(input logic [SampW-1:0] raw,
			input fmt_t fmt);
		logic signed [SampW-1:0] v;
		begin
			unique case (fmt)
				FMT_S8:   v = {{8{raw[7]}}, raw[7:0]};
				FMT_U8:   v = {{8{~raw[7]}}, ~raw[7], raw[6:0]};
				FMT_S16:  v = raw;
				FMT_U16:  v = {~raw[15], raw[14:0]};
				FMT_P10:  v = {{6{raw[9]}}, raw[9:0]};
				FMT_P12:  v = {{4{raw[11]}}, raw[11:0]};
				FMT_P14:  v = {{2{raw[13]}}, raw[13:0]};
				FMT_NONE: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

[src/upk_front.sv]
// ---------------------------------------------------------------------------
// upk_front: bit accumulator of the unpacker
// Appends each accepted byte LSB-first to the pending bits and hands a raw
// I/Q pair to the queue once two samples of the current format are present.
// ---------------------------------------------------------------------------
module upk_front import upk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        in_restart,
	output logic        in_ready,
	input  logic        push_ready,
	output logic        push_valid,
	output pair_t       push_data
);

	fmt_t              fmt_q;
	logic [StoreW-1:0] store_q;
	logic [CountW-1:0] count_q;

	logic [4:0]        width;
	logic [CountW-1:0] need;
	logic [StoreW-1:0] base_store;
	logic [CountW-1:0] base_count;
	logic [StoreW-1:0] add_store;
	logic [CountW-1:0] add_count;
	logic [StoreW-1:0] q_shift;
	logic              emit;
	logic              accept;

	always_comb begin
		width      = fmt_width(fmt_q);
		need       = {width, 1'b0};
		base_store = in_restart ? '0 : store_q;
		base_count = in_restart ? '0 : count_q;
		// The pending count is below 32 here, so the byte always fits.
		add_store  = base_store | ({{(StoreW-8){1'b0}}, in_byte} << base_count);
		add_count  = base_count + CountW'(8);
		emit       = (fmt_q != FMT_NONE) && (add_count >= need);
		q_shift    = add_store >> width;
		push_data.i_raw = add_store[SampW-1:0];
		push_data.q_raw = q_shift[SampW-1:0];
		push_data.fmt   = fmt_q;
	end

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_S8;
			store_q <= '0;
			count_q <= '0;
		end else if (cfg_wr_en) begin
			fmt_q   <= fmt_t'(cfg_wr_data);
			store_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (fmt_q == FMT_NONE) begin
				store_q <= '0;
				count_q <= '0;
			end else if (emit) begin
				store_q <= add_store >> need;
				count_q <= add_count - need;
			end else begin
				store_q <= add_store;
				count_q <= add_count;
			end
		end
	end

endmodule

[src/upk_queue.sv]
// ---------------------------------------------------------------------------
// upk_queue: two-entry queue of raw pairs
// Decouples the accumulator from the output stage so either may stall.
// ---------------------------------------------------------------------------
module upk_queue import upk_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  pair_t push_data,
	output logic  push_ready,
	output logic  pop_valid,
	output pair_t pop_data,
	input  logic  pop_ready
);

	localparam int unsigned PtrW = $clog2(QDepth);
	localparam int unsigned CntW = $clog2(QDepth + 1);

	pair_t           mem_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CntW'(QDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/upk_back.sv]
// ---------------------------------------------------------------------------
// upk_back: sample conversion and output register
// Converts a raw pair to signed 16-bit samples and holds it until taken.
// ---------------------------------------------------------------------------
module upk_back import upk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  pair_t              pop_data,
	output logic               pop_ready,
	output logic               out_valid,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	input  logic               out_ready
);

	logic              valid_q;
	logic signed [15:0] i_q;
	logic signed [15:0] q_q;

	// The register takes a new word whenever it is empty or being emptied.
	assign pop_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_i     = i_q;
	assign out_q     = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			i_q <= to_s16(pop_data.i_raw, pop_data.fmt);
			q_q <= to_s16(pop_data.q_raw, pop_data.fmt);
		end
	end

endmodule

[src/packed_iq_sample_unpacker.sv]
// ---------------------------------------------------------------------------
// packed_iq_sample_unpacker: raw byte stream to complex sample pairs
// Unpacks 8-bit, 16-bit little-endian and LSB-first packed 10/12/14-bit
// interleaved I/Q data into signed 16-bit sample pairs.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] raw byte, tuser restart
//  m_axis    out        tdata[15:0] in-phase, tdata[31:16] quadrature
//  cfg       in         cfg_wr_data[2:0] sample format
//
//  One byte is accepted every cycle while the queue has room; the front end
//  updates its accumulator as each byte is accepted. A pair that an accepted
//  byte completes is written into the queue and passes from there through
//  the output register to m_axis. Reset empties the accumulator, the queue
//  and the output register and selects signed 8-bit. A stalled m_axis fills
//  the two-entry queue before s_axis_tready drops.
// ---------------------------------------------------------------------------
module packed_iq_sample_unpacker import upk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
	input  logic        s_axis_tuser,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [15:0] in_phase, [31:16] quadrature
);

	logic               push_valid;
	logic               push_ready;
	pair_t              push_data;
	logic               pop_valid;
	logic               pop_ready;
	pair_t              pop_data;
	logic signed [15:0] in_phase;
	logic signed [15:0] quadrature;

	upk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_byte    (s_axis_tdata),
		.in_restart (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	upk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	upk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready),
		.out_valid  (m_axis_tvalid),
		.out_i      (in_phase),
		.out_q      (quadrature),
		.out_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {quadrature, in_phase};

endmodule
